>>> hw/rtl/hwss_pkg.sv
// ----------------------------------------------------------------------------
// hwss_pkg
// Shared types and constants for the heartbeat watchdog slew servo core.
// ----------------------------------------------------------------------------
package hwss_pkg;

  // field widths fixed by the interface
  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned STEP_W      = 10;
  localparam int unsigned PERIOD_W    = 8;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned TRIP_W      = 16;
  localparam int unsigned ALARM_W     = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_NORMAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WARNING  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CRITICAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SAFE     = 3'd7;

  // configuration reset values
  localparam logic [MS_W-1:0]     RST_BEAT_TIMEOUT   = 16'd500;
  localparam logic [MS_W-1:0]     RST_GRACE          = 16'd1000;
  localparam logic [STEP_W-1:0]   RST_SLEW_STEP      = 10'd20;
  localparam logic [PERIOD_W-1:0] RST_SLEW_PERIOD    = 8'd5;
  localparam logic [PULSE_W-1:0]  RST_PULSE_NORMAL   = 12'd1167;
  localparam logic [PULSE_W-1:0]  RST_PULSE_WARNING  = 12'd1333;
  localparam logic [PULSE_W-1:0]  RST_PULSE_CRITICAL = 12'd1500;
  localparam logic [PULSE_W-1:0]  RST_PULSE_SAFE     = 12'd2000;

  // servo home position after reset
  localparam logic [PULSE_W-1:0]  HOME_PULSE         = 12'd1000;

  // slew timer saturation point
  localparam logic [PERIOD_W-1:0] SLEW_TIMER_MAX     = 8'hFF;

  // trip counter saturation point
  localparam logic [TRIP_W-1:0]   TRIP_MAX           = 16'hFFFF;

  // alarm level codes
  localparam logic [ALARM_W-1:0]  ALARM_WARNING      = 8'd1;
  localparam logic [ALARM_W-1:0]  ALARM_CRITICAL     = 8'd2;

  // transaction opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BEAT   = 2'd1,
    OP_SENSOR = 2'd2
  } op_e;

  // configuration register set
  typedef struct packed {
    logic [MS_W-1:0]     beat_timeout_ms;
    logic [MS_W-1:0]     grace_ms;
    logic [STEP_W-1:0]   slew_step_us;
    logic [PERIOD_W-1:0] slew_period_ms;
    logic [PULSE_W-1:0]  pulse_normal_us;
    logic [PULSE_W-1:0]  pulse_warning_us;
    logic [PULSE_W-1:0]  pulse_critical_us;
    logic [PULSE_W-1:0]  pulse_safe_us;
  } cfg_t;

endpackage

>>> hw/rtl/hwss_cfg_regs.sv
// ----------------------------------------------------------------------------
// hwss_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hwss_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hwss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hwss_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output hwss_pkg::cfg_t                     cfg_o
);

  hwss_pkg::cfg_t cfg_q;
  hwss_pkg::cfg_t cfg_d;

  // decode the write into the selected field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        hwss_pkg::CFG_BEAT_TIMEOUT:   cfg_d.beat_timeout_ms   = cfg_data_i;
        hwss_pkg::CFG_GRACE:          cfg_d.grace_ms          = cfg_data_i;
        hwss_pkg::CFG_SLEW_STEP:
          cfg_d.slew_step_us      = cfg_data_i[hwss_pkg::STEP_W-1:0];
        hwss_pkg::CFG_SLEW_PERIOD:
          cfg_d.slew_period_ms    = cfg_data_i[hwss_pkg::PERIOD_W-1:0];
        hwss_pkg::CFG_PULSE_NORMAL:
          cfg_d.pulse_normal_us   = cfg_data_i[hwss_pkg::PULSE_W-1:0];
        hwss_pkg::CFG_PULSE_WARNING:
          cfg_d.pulse_warning_us  = cfg_data_i[hwss_pkg::PULSE_W-1:0];
        hwss_pkg::CFG_PULSE_CRITICAL:
          cfg_d.pulse_critical_us = cfg_data_i[hwss_pkg::PULSE_W-1:0];
        hwss_pkg::CFG_PULSE_SAFE:
          cfg_d.pulse_safe_us     = cfg_data_i[hwss_pkg::PULSE_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // register set with defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_timeout_ms   <= hwss_pkg::RST_BEAT_TIMEOUT;
      cfg_q.grace_ms          <= hwss_pkg::RST_GRACE;
      cfg_q.slew_step_us      <= hwss_pkg::RST_SLEW_STEP;
      cfg_q.slew_period_ms    <= hwss_pkg::RST_SLEW_PERIOD;
      cfg_q.pulse_normal_us   <= hwss_pkg::RST_PULSE_NORMAL;
      cfg_q.pulse_warning_us  <= hwss_pkg::RST_PULSE_WARNING;
      cfg_q.pulse_critical_us <= hwss_pkg::RST_PULSE_CRITICAL;
      cfg_q.pulse_safe_us     <= hwss_pkg::RST_PULSE_SAFE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/hwss_slew.sv
// ----------------------------------------------------------------------------
// hwss_slew
// Bounded step of the commanded pulse toward its target.
// ----------------------------------------------------------------------------
module hwss_slew (
  input  logic                            step_en_i,
  input  logic [hwss_pkg::PULSE_W-1:0]    pulse_i,
  input  logic [hwss_pkg::PULSE_W-1:0]    target_i,
  input  logic [hwss_pkg::STEP_W-1:0]     step_i,
  output logic [hwss_pkg::PULSE_W-1:0]    pulse_o
);

  logic                         up;
  logic [hwss_pkg::PULSE_W-1:0] gap;
  logic [hwss_pkg::PULSE_W-1:0] step_ext;

  // distance to target in the direction of travel
  assign up       = target_i > pulse_i;
  assign gap      = up ? (target_i - pulse_i) : (pulse_i - target_i);
  assign step_ext = hwss_pkg::PULSE_W'(step_i);

  // clamp the move so it never overshoots the target
  always_comb begin
    pulse_o = pulse_i;
    if (step_en_i) begin
      if (gap > step_ext) begin
        pulse_o = up ? (pulse_i + step_ext) : (pulse_i - step_ext);
      end else begin
        pulse_o = target_i;
      end
    end
  end

endmodule

>>> hw/rtl/heartbeat_watchdog_slew_servo_core.sv
// ----------------------------------------------------------------------------
// heartbeat_watchdog_slew_servo_core
// Heartbeat watchdog with fail-safe mode, blink LED and slewed servo pulse.
// ----------------------------------------------------------------------------
// datapath: the input register takes a transaction, and the result register
//   loads from it when the result is not stalled
// throughput: one transaction per cycle while the output does not stall; the whole
//   state update of stage two (counters, timeout judge, blink, slew step) is combinational
// reset: counters clear, pulse goes home to 1000 us, blink timer is preloaded
//   so the first toggle is immediate, config registers take their defaults
module heartbeat_watchdog_slew_servo_core #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned BLINK_MS  = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [hwss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hwss_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [hwss_pkg::ALARM_W-1:0]      alarm_level_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hwss_pkg::PULSE_W-1:0]      pulse_width_us_o,
  output logic                              safe_mode_o,
  output logic                              led_on_o,
  output logic [hwss_pkg::TRIP_W-1:0]       trip_total_o,
  output logic                              newly_tripped_o
);

  localparam int unsigned BLINK_W = $clog2(BLINK_MS + 1);
  localparam int unsigned CMP_W   = (TIME_BITS > hwss_pkg::MS_W) ? TIME_BITS : hwss_pkg::MS_W;
  localparam logic [BLINK_W-1:0]   BLINK_END = BLINK_W'(BLINK_MS);
  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};

  hwss_pkg::cfg_t cfg;

  // configuration registers
  hwss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // handshake control
  // --------------------------------------------------------------------------
  logic in_valid_q, in_valid_d;
  logic res_valid_q, res_valid_d;
  logic res_stall;
  logic fire;

  assign res_stall  = res_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && res_stall;
  assign fire       = in_valid_q && !res_stall;

  always_comb begin
    in_valid_d  = in_valid_q;
    res_valid_d = res_valid_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
    end
    if (!res_stall) begin
      res_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // input register
  logic [1:0]                   op_q;
  logic [hwss_pkg::ALARM_W-1:0] alarm_q;

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q    <= op_i;
      alarm_q <= alarm_level_i;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog state
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0]          uptime_q, uptime_d;
  logic [TIME_BITS-1:0]          since_q, since_d;
  logic                          safe_q, safe_d;
  logic                          led_q, led_d;
  logic [hwss_pkg::TRIP_W-1:0]   trip_q, trip_d;
  logic [hwss_pkg::PULSE_W-1:0]  pulse_q, pulse_d;
  logic [hwss_pkg::PERIOD_W-1:0] slew_tmr_q, slew_tmr_d;
  logic [BLINK_W-1:0]            blink_tmr_q, blink_tmr_d;
  logic [hwss_pkg::ALARM_W-1:0]  last_alarm_q, last_alarm_d;
  logic                          newly;
  logic                          is_tick;
  logic                          timed_out;
  logic                          step_en;
  logic [hwss_pkg::PULSE_W-1:0]  target;
  logic [hwss_pkg::PULSE_W-1:0]  slew_pulse;

  assign is_tick = (hwss_pkg::op_e'(op_q) == hwss_pkg::OP_TICK);

  // event, timeout judge and blink
  always_comb begin
    uptime_d     = uptime_q;
    since_d      = since_q;
    slew_tmr_d   = slew_tmr_q;
    blink_tmr_d  = blink_tmr_q;
    last_alarm_d = last_alarm_q;
    safe_d       = safe_q;
    led_d        = led_q;
    trip_d       = trip_q;
    newly        = 1'b0;

    unique case (hwss_pkg::op_e'(op_q))
      hwss_pkg::OP_TICK: begin
        if (uptime_d != TIME_MAX) uptime_d = uptime_q + TIME_BITS'(1);
        if (since_d != TIME_MAX)  since_d  = since_q + TIME_BITS'(1);
        if (slew_tmr_q != hwss_pkg::SLEW_TIMER_MAX) begin
          slew_tmr_d = slew_tmr_q + hwss_pkg::PERIOD_W'(1);
        end
        if (blink_tmr_q < BLINK_END) blink_tmr_d = blink_tmr_q + BLINK_W'(1);
      end
      hwss_pkg::OP_BEAT:   since_d      = '0;
      hwss_pkg::OP_SENSOR: last_alarm_d = alarm_q;
      default: ;
    endcase

    timed_out = (CMP_W'(uptime_d) > CMP_W'(cfg.grace_ms)) &&
                (CMP_W'(since_d) > CMP_W'(cfg.beat_timeout_ms));

    if (timed_out) begin
      if (!safe_q) begin
        safe_d = 1'b1;
        newly  = 1'b1;
        if (trip_q != hwss_pkg::TRIP_MAX) trip_d = trip_q + hwss_pkg::TRIP_W'(1);
      end
      if (blink_tmr_d >= BLINK_END) begin
        blink_tmr_d = '0;
        led_d       = !led_q;
      end
    end else begin
      safe_d = 1'b0;
    end
  end

  // target pulse selection
  always_comb begin
    priority if (safe_d) begin
      target = cfg.pulse_safe_us;
    end else if (last_alarm_d == hwss_pkg::ALARM_WARNING) begin
      target = cfg.pulse_warning_us;
    end else if (last_alarm_d == hwss_pkg::ALARM_CRITICAL) begin
      target = cfg.pulse_critical_us;
    end else begin
      target = cfg.pulse_normal_us;
    end
  end

  assign step_en = is_tick && (pulse_q != target) && (slew_tmr_d >= cfg.slew_period_ms);

  // slew step
  hwss_slew u_slew (
    .step_en_i (step_en),
    .pulse_i   (pulse_q),
    .target_i  (target),
    .step_i    (cfg.slew_step_us),
    .pulse_o   (slew_pulse)
  );

  assign pulse_d = slew_pulse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uptime_q     <= '0;
      since_q      <= '0;
      safe_q       <= 1'b0;
      led_q        <= 1'b0;
      trip_q       <= '0;
      pulse_q      <= hwss_pkg::HOME_PULSE;
      slew_tmr_q   <= '0;
      blink_tmr_q  <= BLINK_END;
      last_alarm_q <= '0;
    end else if (fire) begin
      uptime_q     <= uptime_d;
      since_q      <= since_d;
      safe_q       <= safe_d;
      led_q        <= led_d;
      trip_q       <= trip_d;
      pulse_q      <= pulse_d;
      slew_tmr_q   <= step_en ? '0 : slew_tmr_d;
      blink_tmr_q  <= blink_tmr_d;
      last_alarm_q <= last_alarm_d;
    end
  end

  // result register
  logic [hwss_pkg::PULSE_W-1:0] res_pulse_q;
  logic                         res_safe_q;
  logic                         res_led_q;
  logic [hwss_pkg::TRIP_W-1:0]  res_trip_q;
  logic                         res_newly_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_pulse_q <= pulse_d;
      res_safe_q  <= safe_d;
      res_led_q   <= led_d;
      res_trip_q  <= trip_d;
      res_newly_q <= newly;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign pulse_width_us_o = res_pulse_q;
  assign safe_mode_o      = res_safe_q;
  assign led_on_o         = res_led_q;
  assign trip_total_o     = res_trip_q;
  assign newly_tripped_o  = res_newly_q;

`ifndef NO_ASSERTIONS
  // a fresh trip is always reported together with safe mode
  a_newly_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && newly_tripped_o |-> safe_mode_o)
    else $error("newly tripped without safe mode");

  // safe-mode entry bumps the trip count unless saturated
  a_trip_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(safe_q) |-> (trip_q == $past(trip_q) + hwss_pkg::TRIP_W'(1)) ||
                      (trip_q == hwss_pkg::TRIP_MAX))
    else $error("trip count did not follow safe entry");

  // uptime only moves forward
  a_uptime_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> uptime_q >= $past(uptime_q))
    else $error("uptime went backward");

  // the pulse never moves farther than one slew step
  a_slew_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((pulse_q >= $past(pulse_q)) ?
              (pulse_q - $past(pulse_q)) : ($past(pulse_q) - pulse_q))
             <= hwss_pkg::PULSE_W'($past(cfg.slew_step_us)))
    else $error("pulse moved more than one step");

  // a stalled input register keeps its transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && res_stall |=> in_valid_q && $stable(op_q) && $stable(alarm_q))
    else $error("input register lost a stalled transaction");
`endif

endmodule
